/* hw/rtl/ppr_pkg.sv */
// shared constants, widths and control structs for the paired-point rmsd block
// no dependencies
package ppr_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int COORD_BITS = 24;

  localparam int CNT_W  = 13;
  localparam int MAG_W  = COORD_BITS;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM3_W = SQ_W + 2;
  localparam int ACC_W  = 64;
  localparam int RMSD_W = 25;
  localparam int REM_W  = CNT_W;

  localparam int DIV_STEPS  = ACC_W;
  localparam int ROOT_STEPS = ACC_W / 2;
  localparam int STEP_W     = 6;

  localparam logic [ACC_W-1:0] ROOT_BIT0 = ACC_W'(1) << (ACC_W - 2);

  typedef struct packed {
    logic take;
    logic div_load;
    logic div_step;
    logic root_init;
    logic root_step;
    logic out_load;
  } ppr_cmd_t;

  typedef struct packed {
    logic tail_done;
  } ppr_sts_t;

endpackage

/* hw/rtl/ppr_in_if.sv */
// input channel: one paired point per word, valid/ready handshake
// depends on ppr_pkg
interface ppr_in_if;
  import ppr_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ref_x;
  logic signed [COORD_BITS-1:0] ref_y;
  logic signed [COORD_BITS-1:0] ref_z;
  logic signed [COORD_BITS-1:0] mov_x;
  logic signed [COORD_BITS-1:0] mov_y;
  logic signed [COORD_BITS-1:0] mov_z;
  logic                         last_pair;

  modport source (output valid, ref_x, ref_y, ref_z, mov_x, mov_y, mov_z, last_pair,
                  input ready);
  modport sink (input valid, ref_x, ref_y, ref_z, mov_x, mov_y, mov_z, last_pair,
                output ready);
endinterface

/* hw/rtl/ppr_out_if.sv */
// result channel: rmsd and pair count per word, valid/ready handshake
// depends on ppr_pkg
interface ppr_out_if;
  import ppr_pkg::*;

  logic              valid;
  logic              ready;
  logic [RMSD_W-1:0] rmsd_value;
  logic [CNT_W-1:0]  pairs_used;

  modport source (output valid, rmsd_value, pairs_used, input ready);
  modport sink (input valid, rmsd_value, pairs_used, output ready);
endinterface

/* hw/rtl/ppr_ctrl.sv */
// controller: accept phase, pipeline drain, divide and root sequencing, result slot
// depends on ppr_pkg
module ppr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  ppr_pkg::ppr_sts_t sts,
  output ppr_pkg::ppr_cmd_t cmd
);
  import ppr_pkg::*;

  typedef enum logic [5:0] {
    S_ACC   = 6'b000001,
    S_DRAIN = 6'b000010,
    S_DIV   = 6'b000100,
    S_RINIT = 6'b001000,
    S_ROOT  = 6'b010000,
    S_DONE  = 6'b100000
  } ppr_state_t;

  ppr_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready      = (state_r == S_ACC);
    unique case (state_r)
      S_ACC: begin
        cmd.take = in_valid;
        if (in_valid && in_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // wait until the final word has reached the accumulator
        if (sts.tail_done) begin
          cmd.div_load = 1'b1;
          cnt_nxt      = STEP_W'(DIV_STEPS - 1);
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_RINIT;
        end
      end
      S_RINIT: begin
        cmd.root_init = 1'b1;
        cnt_nxt       = STEP_W'(ROOT_STEPS - 1);
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // result register must be free or draining this cycle
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken word");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> (state_r == S_DRAIN))
    else $error("final word did not start the drain");

  a_div_to_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == '0) |=> (state_r == S_RINIT))
    else $error("divide did not hand over to the root");

  a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT && cnt_r == '0) |=> (state_r == S_DONE))
    else $error("root did not finish on the last step");

endmodule

/* hw/rtl/ppr_dp.sv */
// datapath: difference/square/accumulate pipeline, restoring divider, bitwise root
// depends on ppr_pkg
module ppr_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ppr_pkg::ppr_cmd_t                     cmd,
  output ppr_pkg::ppr_sts_t                     sts,
  input  logic                                  cfg_we,
  input  logic [ppr_pkg::CNT_W-1:0]             cfg_wdata,
  input  logic signed [ppr_pkg::COORD_BITS-1:0] ref_x,
  input  logic signed [ppr_pkg::COORD_BITS-1:0] ref_y,
  input  logic signed [ppr_pkg::COORD_BITS-1:0] ref_z,
  input  logic signed [ppr_pkg::COORD_BITS-1:0] mov_x,
  input  logic signed [ppr_pkg::COORD_BITS-1:0] mov_y,
  input  logic signed [ppr_pkg::COORD_BITS-1:0] mov_z,
  input  logic                                  last_pair,
  output logic [ppr_pkg::RMSD_W-1:0]            rmsd_value,
  output logic [ppr_pkg::CNT_W-1:0]             pairs_used
);
  import ppr_pkg::*;

  logic [CNT_W-1:0]  limit_r, eff_limit, pair_count_r;
  logic              counted;
  logic [MAG_W-1:0]  mag [3];
  logic [MAG_W-1:0]  mag1_r [3];
  logic [SQ_W-1:0]   sq2_r [3];
  logic [SUM3_W-1:0] sum3_r;
  logic              v1_r, v2_r, v3_r, l1_r, l2_r, l3_r;
  logic [ACC_W-1:0]  acc_r;
  logic              tail_r;
  logic [ACC_W-1:0]  dvd_r;
  logic [REM_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [REM_W:0]    trial;
  logic [ACC_W-1:0]  x_r, res_r, bit_r, rb;
  logic [RMSD_W-1:0] rmsd_r;
  logic [CNT_W-1:0]  used_r;

  assign eff_limit = (limit_r > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : limit_r;
  assign counted   = (pair_count_r < eff_limit);

  function automatic logic [MAG_W-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                                input logic signed [COORD_BITS-1:0] b);
    logic signed [COORD_BITS:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    abs_diff = d[COORD_BITS] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  // pairs past the limit enter the pipe as zero
  always_comb begin
    mag[0] = counted ? abs_diff(ref_x, mov_x) : '0;
    mag[1] = counted ? abs_diff(ref_y, mov_y) : '0;
    mag[2] = counted ? abs_diff(ref_z, mov_z) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= CNT_W'(MAX_POINTS);
      pair_count_r <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      acc_r        <= '0;
      tail_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      v1_r <= cmd.take;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.div_load) begin
        pair_count_r <= '0;
        acc_r        <= '0;
        tail_r       <= 1'b0;
      end else begin
        if (cmd.take && counted) begin
          pair_count_r <= pair_count_r + 1'b1;
        end
        if (v3_r) begin
          acc_r <= acc_r + ACC_W'(sum3_r);
          if (l3_r) begin
            tail_r <= 1'b1;
          end
        end
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mag1_r <= mag;
      l1_r   <= last_pair;
    end
    l2_r <= l1_r;
    l3_r <= l2_r;
    for (int i = 0; i < 3; i++) begin
      sq2_r[i] <= SQ_W'(mag1_r[i]) * SQ_W'(mag1_r[i]);
    end
    sum3_r <= SUM3_W'(sq2_r[0]) + SUM3_W'(sq2_r[1]) + SUM3_W'(sq2_r[2]);
  end

  assign sts.tail_done = tail_r;

  // restoring divide, one quotient bit per cycle shifted into dvd_r
  assign trial = {rem_r, dvd_r[ACC_W-1]};
  assign rb    = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd_r <= acc_r;
      rem_r <= '0;
      dvs_r <= pair_count_r;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_r <= REM_W'(trial - {1'b0, dvs_r});
        dvd_r <= {dvd_r[ACC_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[REM_W-1:0];
        dvd_r <= {dvd_r[ACC_W-2:0], 1'b0};
      end
    end

    // square root, two radicand bits per cycle
    if (cmd.root_init) begin
      x_r   <= dvd_r;
      res_r <= '0;
      bit_r <= ROOT_BIT0;
    end else if (cmd.root_step) begin
      if (x_r >= rb) begin
        x_r   <= x_r - rb;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end

    if (cmd.out_load) begin
      rmsd_r <= (dvs_r == '0) ? '0 : res_r[RMSD_W-1:0];
      used_r <= dvs_r;
    end
  end

  assign rmsd_value = rmsd_r;
  assign pairs_used = used_r;

endmodule

/* hw/rtl/paired_point_rmsd_core.sv */
// paired-point rmsd: one pair word accepted per cycle while a set streams in.
// the word marked last is followed by a tail before the result is valid: pipeline
// drain, 64 divide steps, root init and 32 root steps, then the result load.
// no pair word is taken during that tail; the result register holds one word.
// synchronous active-low reset clears sums, counts, state and sets the limit to 4096.
module paired_point_rmsd_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [ppr_pkg::CNT_W-1:0] cfg_wdata,
  ppr_in_if.sink                    in_ch,
  ppr_out_if.source                 out_ch
);
  import ppr_pkg::*;

  ppr_cmd_t cmd;
  ppr_sts_t sts;

  ppr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_pair),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  ppr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .ref_x      (in_ch.ref_x),
    .ref_y      (in_ch.ref_y),
    .ref_z      (in_ch.ref_z),
    .mov_x      (in_ch.mov_x),
    .mov_y      (in_ch.mov_y),
    .mov_z      (in_ch.mov_z),
    .last_pair  (in_ch.last_pair),
    .rmsd_value (out_ch.rmsd_value),
    .pairs_used (out_ch.pairs_used)
  );

endmodule
